[design/ssdg_pkg.sv]
// ----------------------------------------------------------------------------
// ssdg_pkg
// Shared types and constants for the step/direction pulse generator.
// ----------------------------------------------------------------------------
package ssdg_pkg;

  localparam int OP_W       = 3;
  localparam int VALUE_W    = 32;
  localparam int WORD_W     = 16;
  localparam int BIT_IDX_W  = 4;
  localparam int INTERVAL_W = 20;
  localparam int PULSE_W    = 11;
  localparam int SINCE_W    = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 88;

  localparam logic [PULSE_W-1:0] PULSE_MAX_US = 11'd2000;
  localparam logic [SINCE_W-1:0] SINCE_MAX    = {SINCE_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_MOVE_TO  = 3'd1,
    OP_MOVE_REL = 3'd2,
    OP_STOP     = 3'd3,
    OP_SET_POS  = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_BIT     = 3'd0,
    CFG_DIR_BIT      = 3'd1,
    CFG_INTERVAL     = 3'd2,
    CFG_PULSE_WIDTH  = 3'd3,
    CFG_DIR_INVERTED = 3'd4,
    CFG_ALWAYS_EN    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic                      step_fired;
    logic signed [VALUE_W-1:0] distance_to_go;
    logic signed [VALUE_W-1:0] position;
    logic [WORD_W-1:0]         out_word;
  } result_t;

endpackage

[design/stepper_step_dir_generator.sv]
// ----------------------------------------------------------------------------
// stepper_step_dir_generator
// Single-axis constant-rate step/dir generator producing a 16-bit output word.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one request per item: a one-microsecond tick or a
//   command (move-to, move-relative, stop, set-position). Every request gives
//   exactly one result on the m_ channel: the output word, position, distance
//   to go and a step flag.
//   Results are registered; a request accepted while the output is free shows
//   on m_tvalid in the cycle after. One request is taken per cycle while
//   s_tready is high, with a single state update before the result register.
//   A skid register behind the result register lets one more request in while
//   the receiver stalls; s_tready drops only once both are full, and results
//   are held unchanged until taken.
//   The cfg port writes one register per cycle with cfg_we; the user must make
//   writes only while no request is in flight; the block does not enforce it.
//   Reset (rst, synchronous) clears position, target, elapsed time, pulse
//   slots, output word and the valid flags of both result registers, and
//   restores the register defaults. There is no clearing pass.
// ----------------------------------------------------------------------------
module stepper_step_dir_generator #(
  parameter int PULSE_SLOTS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [2:0] op, [34:3] value, [39:35] zero
  input  logic [ssdg_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [15:0] out_word, [47:16] position, [79:48] distance_to_go,
  // [80] step_fired, [87:81] zero
  output logic [ssdg_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                             cfg_we,
  input  logic [ssdg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssdg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ssdg_pkg::*;

  // configuration
  logic [BIT_IDX_W-1:0]  step_bit_index;
  logic [BIT_IDX_W-1:0]  dir_bit_index;
  logic [INTERVAL_W-1:0] step_interval_us;
  logic [PULSE_W-1:0]    pulse_width_us;
  logic                  dir_inverted;
  logic                  always_enabled;

  // state
  logic [WORD_W-1:0]     word_reg;
  logic [VALUE_W-1:0]    position_count;
  logic [VALUE_W-1:0]    target_count;
  logic [SINCE_W-1:0]    since_step_us;
  logic [PULSE_SLOTS-1:0] slot_busy;
  logic [BIT_IDX_W-1:0]  slot_bit_index [PULSE_SLOTS];
  logic [PULSE_W-1:0]    slot_remaining_us [PULSE_SLOTS];

  logic [WORD_W-1:0]     word_next;
  logic [VALUE_W-1:0]    position_next;
  logic [VALUE_W-1:0]    target_next;
  logic [SINCE_W-1:0]    since_next;
  logic [PULSE_SLOTS-1:0] busy_next;
  logic [BIT_IDX_W-1:0]  bit_next [PULSE_SLOTS];
  logic [PULSE_W-1:0]    rem_next [PULSE_SLOTS];
  logic                  fired;

  // result register and skid stage
  result_t result;
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;
  logic    accept;

  op_t                   op;
  logic [VALUE_W-1:0]    value;
  logic [VALUE_W-1:0]    distance;
  logic [PULSE_W-1:0]    pw_eff;

  assign op     = op_t'(s_tdata[OP_W-1:0]);
  assign value  = s_tdata[OP_W +: VALUE_W];
  assign accept = s_tvalid && s_tready;
  assign s_tready = !skid_valid;
  assign distance = target_count - position_count;

  always_comb begin
    if (pulse_width_us == '0) begin
      pw_eff = PULSE_W'(1);
    end else if (pulse_width_us > PULSE_MAX_US) begin
      pw_eff = PULSE_MAX_US;
    end else begin
      pw_eff = pulse_width_us;
    end
  end

  // next state for one request
  always_comb begin
    logic taken;
    logic fwd;
    taken         = 1'b0;
    fwd           = !distance[VALUE_W-1];
    fired         = 1'b0;
    word_next     = word_reg;
    position_next = position_count;
    target_next   = target_count;
    since_next    = since_step_us;
    busy_next     = slot_busy;
    for (int i = 0; i < PULSE_SLOTS; i++) begin
      bit_next[i] = slot_bit_index[i];
      rem_next[i] = slot_remaining_us[i];
    end

    unique case (op)
      OP_TICK: begin
        // age slots, drop the bit of every slot that runs out
        for (int i = 0; i < PULSE_SLOTS; i++) begin
          if (slot_busy[i]) begin
            if (rem_next[i] != '0) begin
              rem_next[i] = rem_next[i] - PULSE_W'(1);
            end
            if (rem_next[i] == '0) begin
              busy_next[i] = 1'b0;
              word_next[slot_bit_index[i]] = 1'b0;
            end
          end
        end
        if (since_step_us != SINCE_MAX) begin
          since_next = since_step_us + SINCE_W'(1);
        end
        if (distance != '0 && step_interval_us != '0 &&
            since_next >= {1'b0, step_interval_us}) begin
          fired      = 1'b1;
          since_next = '0;
          word_next[dir_bit_index] = fwd ^ dir_inverted;
          // book the lowest free slot
          for (int i = 0; i < PULSE_SLOTS; i++) begin
            if (!busy_next[i] && !taken) begin
              busy_next[i] = 1'b1;
              bit_next[i]  = step_bit_index;
              rem_next[i]  = pw_eff;
              taken        = 1'b1;
            end
          end
          word_next[step_bit_index] = 1'b1;
          position_next = fwd ? position_count + VALUE_W'(1)
                              : position_count - VALUE_W'(1);
        end
      end
      OP_MOVE_TO: begin
        target_next = value;
      end
      OP_MOVE_REL: begin
        target_next = position_count + value;
      end
      OP_STOP: begin
        target_next = position_count;
      end
      OP_SET_POS: begin
        position_next = value;
        target_next   = value;
      end
      default: begin
      end
    endcase

    if (always_enabled) begin
      word_next[0] = 1'b0;
    end
  end

  always_comb begin
    result.out_word       = word_next;
    result.position       = position_next;
    result.distance_to_go = target_next - position_next;
    result.step_fired     = fired;
  end

  // configuration writes and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      step_bit_index   <= BIT_IDX_W'(1);
      dir_bit_index    <= BIT_IDX_W'(2);
      step_interval_us <= '0;
      pulse_width_us   <= PULSE_W'(1);
      dir_inverted     <= 1'b0;
      always_enabled   <= 1'b1;
      word_reg         <= '0;
      position_count   <= '0;
      target_count     <= '0;
      since_step_us    <= '0;
      slot_busy        <= '0;
      for (int i = 0; i < PULSE_SLOTS; i++) begin
        slot_bit_index[i]    <= '0;
        slot_remaining_us[i] <= '0;
      end
    end else begin
      if (accept) begin
        word_reg       <= word_next;
        position_count <= position_next;
        target_count   <= target_next;
        since_step_us  <= since_next;
        slot_busy      <= busy_next;
        for (int i = 0; i < PULSE_SLOTS; i++) begin
          slot_bit_index[i]    <= bit_next[i];
          slot_remaining_us[i] <= rem_next[i];
        end
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_STEP_BIT:     step_bit_index   <= cfg_data[BIT_IDX_W-1:0];
          CFG_DIR_BIT:      dir_bit_index    <= cfg_data[BIT_IDX_W-1:0];
          CFG_INTERVAL:     step_interval_us <= cfg_data[INTERVAL_W-1:0];
          CFG_PULSE_WIDTH:  pulse_width_us   <= cfg_data[PULSE_W-1:0];
          CFG_DIR_INVERTED: dir_inverted     <= cfg_data[0];
          CFG_ALWAYS_EN: begin
            always_enabled <= cfg_data[0];
            // enabling drops the shared enable bit at once
            if (cfg_data[0]) begin
              word_reg[0] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (accept) begin
        out_reg <= result;
      end
    end else if (accept) begin
      skid_reg <= result;
    end
  end

  assign m_tdata = {7'b0, out_reg.step_fired, out_reg.distance_to_go,
                    out_reg.position, out_reg.out_word};

endmodule

[design/ssdg_checker.sv]
// ----------------------------------------------------------------------------
// ssdg_checker
// Port-level checks for the step/dir generator, bound to the top level.
// ----------------------------------------------------------------------------
module ssdg_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ssdg_pkg::M_TDATA_W-1:0]  m_tdata
);
  import ssdg_pkg::*;

  // no result survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // back-pressure only while a result waits
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input blocked with no result pending");

  // after every accepted request a result is valid in the next cycle
  a_req_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted request produced no result");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_TDATA_W-1:81] == '0)
    else $error("result padding not zero");

endmodule

bind stepper_step_dir_generator ssdg_checker u_ssdg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the step/direction pulse generator. A directed table
// covers the command set, unused opcodes, pulse width clamping, slot
// exhaustion, position wrap and the enable bit. Randomised phases with fresh
// register settings follow. Each request is predicted by a cycle-free axis
// model or a checked row; every result is compared field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ssdg_pkg::*;

  localparam int PULSE_SLOTS   = 4;
  localparam int LONG_HOLD     = 200;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 78;
  localparam int DIRECTED_ROWS = 34;

  localparam logic [OP_W-1:0]      OP_SPARE_5  = 3'd5;
  localparam logic [OP_W-1:0]      OP_SPARE_6  = 3'd6;
  localparam logic [OP_W-1:0]      OP_SPARE_7  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [2:0]        code;
    logic [31:0]       value;
    logic              checked;
    logic [WORD_W-1:0] e_word;
    logic [31:0]       e_pos;
    logic [31:0]       e_dist;
    logic              e_fired;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Axis model state and its register copy
  logic [WORD_W-1:0]     out_bits;
  logic [31:0]           axis_pos;
  logic [31:0]           axis_target;
  logic [SINCE_W-1:0]    axis_since;
  logic                  pulse_busy [PULSE_SLOTS];
  logic [BIT_IDX_W-1:0]  pulse_bit  [PULSE_SLOTS];
  logic [PULSE_W-1:0]    pulse_left [PULSE_SLOTS];
  logic [BIT_IDX_W-1:0]  c_step_bit;
  logic [BIT_IDX_W-1:0]  c_dir_bit;
  logic [INTERVAL_W-1:0] c_interval;
  logic [PULSE_W-1:0]    c_pulse_width;
  logic                  c_dir_inv;
  logic                  c_always_en;

  result_t pending_outputs [$];
  row_t    directed_rows [DIRECTED_ROWS];
  int      mismatch_count = 0;
  bit      hold_off_req = 1'b0;

  always #4 clk = ~clk;

  stepper_step_dir_generator #(
    .PULSE_SLOTS(PULSE_SLOTS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  function automatic void load_setting(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_STEP_BIT:     c_step_bit    = data[BIT_IDX_W-1:0];
      CFG_DIR_BIT:      c_dir_bit     = data[BIT_IDX_W-1:0];
      CFG_INTERVAL:     c_interval    = data[INTERVAL_W-1:0];
      CFG_PULSE_WIDTH:  c_pulse_width = data[PULSE_W-1:0];
      CFG_DIR_INVERTED: c_dir_inv     = data[0];
      CFG_ALWAYS_EN: begin
        c_always_en = data[0];
        if (data[0]) out_bits[0] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Apply one request to the axis model and return the result it should produce
  function automatic result_t axis_advance(input logic [OP_W-1:0] op,
                                           input logic [31:0] value);
    result_t            r;
    logic [31:0]        distance;
    logic               fwd;
    logic               booked;
    logic               fired;
    logic [PULSE_W-1:0] width;
    fired = 1'b0;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < PULSE_SLOTS; i++) begin
          if (pulse_busy[i]) begin
            if (pulse_left[i] != '0) pulse_left[i] = pulse_left[i] - 1'b1;
            if (pulse_left[i] == '0) begin
              pulse_busy[i] = 1'b0;
              out_bits[pulse_bit[i]] = 1'b0;
            end
          end
        end
        if (axis_since != SINCE_MAX) axis_since = axis_since + 1'b1;
        distance = axis_target - axis_pos;
        if (distance != '0 && c_interval != '0 &&
            axis_since >= SINCE_W'(c_interval)) begin
          fired = 1'b1;
          axis_since = '0;
          fwd = ~distance[31];
          out_bits[c_dir_bit] = fwd ^ c_dir_inv;
          width = c_pulse_width;
          if (width == '0) width = PULSE_W'(1);
          if (width > PULSE_MAX_US) width = PULSE_MAX_US;
          booked = 1'b0;
          for (int i = 0; i < PULSE_SLOTS; i++) begin
            if (!booked && !pulse_busy[i]) begin
              booked = 1'b1;
              pulse_busy[i] = 1'b1;
              pulse_bit[i] = c_step_bit;
              pulse_left[i] = width;
            end
          end
          // with every slot taken the bit stays high until a slot on it expires
          out_bits[c_step_bit] = 1'b1;
          axis_pos = fwd ? axis_pos + 1 : axis_pos - 1;
        end
      end
      OP_MOVE_TO:  axis_target = value;
      OP_MOVE_REL: axis_target = axis_pos + value;
      OP_STOP:     axis_target = axis_pos;
      OP_SET_POS: begin
        axis_pos = value;
        axis_target = value;
      end
      default: ;
    endcase
    if (c_always_en) out_bits[0] = 1'b0;
    r.out_word       = out_bits;
    r.position       = axis_pos;
    r.distance_to_go = axis_target - axis_pos;
    r.step_fired     = fired;
    return r;
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [31:0] value,
                              input logic use_typed, input result_t typed);
    result_t predicted;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - VALUE_W - OP_W){1'b0}}, value, op};
    do @(posedge clk); while (!s_tready);
    predicted = axis_advance(op, value);
    pending_outputs.push_back(use_typed ? typed : predicted);
  endtask

  // Hold the sender until every result is back, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    load_setting(idx, data);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      if (mismatch_count < 60)
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(result_t)-1:0];
      if (pending_outputs.size() == 0) begin
        if (mismatch_count < 60)
          $display("%0t: result with no request outstanding, expected none actual %h",
                   $time, got);
        mismatch_count++;
      end else begin
        want = pending_outputs.pop_front();
        compare_field("out_word", 32'(want.out_word), 32'(got.out_word));
        compare_field("position", want.position, got.position);
        compare_field("distance_to_go", want.distance_to_go, got.distance_to_go);
        compare_field("step_fired", 32'(want.step_fired), 32'(got.step_fired));
      end
    end
  end

  // Receiver: alternate stall patterns, with one long hold-off on request
  initial begin : result_sink
    int mode;
    int seg_len;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
      end
      mode = $urandom_range(0, 3);
      seg_len = $urandom_range(4, 48);
      for (int k = 0; k < seg_len && !hold_off_req; k++) begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= (k % 4 == 3);
          default: m_tready <= (k % 8 < 5);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    row_t                  row;
    result_t               typed;
    logic                  in_cfg;
    logic [OP_W-1:0]       op;
    logic [31:0]           val;
    logic [BIT_IDX_W-1:0]  step_b;
    logic [BIT_IDX_W-1:0]  dir_b;
    logic [INTERVAL_W-1:0] ival;
    logic [PULSE_W-1:0]    pw;
    logic                  inv;
    logic                  en;
    int                    roll;
    int                    burst;
    int                    gap;
    int                    w;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;

    c_step_bit = 1; c_dir_bit = 2; c_interval = '0; c_pulse_width = 1;
    c_dir_inv = 1'b0; c_always_en = 1'b1;
    out_bits = '0; axis_pos = '0; axis_target = '0; axis_since = '0;
    for (int i = 0; i < PULSE_SLOTS; i++) begin
      pulse_busy[i] = 1'b0;
      pulse_bit[i]  = '0;
      pulse_left[i] = '0;
    end

    directed_rows = '{
      // reset settings: interval zero, so ticks never step
      '{ROW_ITEM, OP_TICK,     32'h0000_0000, 1'b1, 16'h0, 32'h0,         32'h0,         1'b0},
      '{ROW_ITEM, OP_MOVE_TO,  32'h7FFF_FFFF, 1'b1, 16'h0, 32'h0,         32'h7FFF_FFFF, 1'b0},
      '{ROW_ITEM, OP_TICK,     32'hFFFF_FFFF, 1'b1, 16'h0, 32'h0,         32'h7FFF_FFFF, 1'b0},
      '{ROW_ITEM, OP_SET_POS,  32'h8000_0000, 1'b1, 16'h0, 32'h8000_0000, 32'h0,         1'b0},
      '{ROW_ITEM, OP_MOVE_REL, 32'hFFFF_FFFF, 1'b1, 16'h0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0},
      '{ROW_ITEM, OP_STOP,     32'h1234_5678, 1'b1, 16'h0, 32'h8000_0000, 32'h0,         1'b0},
      '{ROW_ITEM, OP_SPARE_5,  32'hFFFF_FFFF, 1'b1, 16'h0, 32'h8000_0000, 32'h0,         1'b0},
      '{ROW_ITEM, OP_SPARE_7,  32'h0000_0000, 1'b1, 16'h0, 32'h8000_0000, 32'h0,         1'b0},
      // step every tick, zero pulse width, a write to an unused index
      '{ROW_CFG,  CFG_INTERVAL,    32'h1,     1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_CFG,  CFG_PULSE_WIDTH, 32'h0,     1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_CFG,  CFG_SPARE_6,     32'hFFFFF, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_ITEM, OP_SET_POS,  32'h7FFF_FFFE, 1'b1, 16'h0, 32'h7FFF_FFFE, 32'h0, 1'b0},
      '{ROW_ITEM, OP_MOVE_REL, 32'h0000_0003, 1'b1, 16'h0, 32'h7FFF_FFFE, 32'h3, 1'b0},
      // forward across the positive limit
      '{ROW_ITEM, OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_ITEM, OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_ITEM, OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_ITEM, OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      // over-long pulses, step on the top bit, direction on the enable bit
      '{ROW_CFG,  CFG_PULSE_WIDTH,  32'h7FF, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_CFG,  CFG_STEP_BIT,     32'hF,   1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_CFG,  CFG_DIR_BIT,      32'h0,   1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_CFG,  CFG_DIR_INVERTED, 32'h1,   1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_ITEM, OP_MOVE_REL, 32'hFFFF_FFFA, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      // run out of pulse slots
      '{ROW_ITEM, OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_ITEM, OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_ITEM, OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_ITEM, OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_ITEM, OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_ITEM, OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      // release the enable bit so the direction level shows on it
      '{ROW_CFG,  CFG_ALWAYS_EN, 32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_CFG,  CFG_SPARE_7,   32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_ITEM, OP_MOVE_TO, 32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_ITEM, OP_TICK,    32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_ITEM, OP_TICK,    32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0},
      '{ROW_ITEM, OP_TICK,    32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    in_cfg = 1'b0;
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG) begin
        if (!in_cfg) drain();
        in_cfg = 1'b1;
        cfg_write(row.code, row.value[CFG_DATA_W-1:0]);
      end else begin
        if (in_cfg) cfg_we <= 1'b0;
        in_cfg = 1'b0;
        typed.out_word       = row.e_word;
        typed.position       = row.e_pos;
        typed.distance_to_go = row.e_dist;
        typed.step_fired     = row.e_fired;
        send_request(row.code, row.value, row.checked, typed);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      step_b = 4'($urandom);
      dir_b  = 4'($urandom);
      inv    = 1'($urandom);
      en     = 1'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 10)      ival = '0;
      else if (roll < 80) ival = INTERVAL_W'($urandom_range(1, 6));
      else                ival = INTERVAL_W'($urandom_range(7, 40));
      roll = $urandom_range(0, 99);
      if (roll < 60)      pw = PULSE_W'($urandom_range(1, 8));
      else if (roll < 75) pw = '0;
      else if (roll < 85) pw = PULSE_MAX_US;
      else if (roll < 92) pw = '1;
      else                pw = PULSE_W'($urandom);
      case (p)
        0: begin ival = 20'd1000000; pw = PULSE_MAX_US; end
        1: begin ival = '1; pw = 11'd1; end
        2: begin ival = 20'd1; pw = 11'd1; en = 1'b0; end
        3: begin ival = 20'd1; pw = '1; dir_b = step_b; end
        default: ;
      endcase
      // junk above the used bits must be ignored
      cfg_write(CFG_STEP_BIT,     CFG_DATA_W'({16'($urandom), step_b}));
      cfg_write(CFG_DIR_BIT,      CFG_DATA_W'({16'($urandom), dir_b}));
      cfg_write(CFG_INTERVAL,     ival);
      cfg_write(CFG_PULSE_WIDTH,  CFG_DATA_W'({9'($urandom), pw}));
      cfg_write(CFG_DIR_INVERTED, CFG_DATA_W'({19'($urandom), inv}));
      cfg_write(CFG_ALWAYS_EN,    CFG_DATA_W'({19'($urandom), en}));
      if (p % 3 == 1) cfg_write(($urandom_range(0, 1) != 0) ? CFG_SPARE_6 : CFG_SPARE_7,
                                CFG_DATA_W'($urandom));
      cfg_we <= 1'b0;

      burst = $urandom_range(1, 30);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 8) hold_off_req = 1'b1;
        if (p == 6 && n == PHASE_ITEMS / 2) drain();
        roll = $urandom_range(0, 99);
        val = $urandom;
        if (roll < 78) op = OP_TICK;
        else if (roll < 84) begin
          op = OP_MOVE_TO;
          if ($urandom_range(0, 9) < 7) val = axis_pos + 32'($signed($urandom_range(0, 60)) - 30);
        end else if (roll < 91) begin
          op = OP_MOVE_REL;
          if ($urandom_range(0, 9) < 8) val = 32'($signed($urandom_range(0, 60)) - 30);
        end else if (roll < 94) op = OP_STOP;
        else if (roll < 96) op = OP_SET_POS;
        else if (roll < 98) op = OP_SPARE_5;
        else if (roll < 99) op = OP_SPARE_6;
        else                op = OP_SPARE_7;
        send_request(op, val, 1'b0, '0);
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 30);
          gap = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : 0;
          if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    s_tvalid <= 1'b0;
    for (w = 0; w < 20000 && pending_outputs.size() != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_outputs.size() != 0) begin
      $display("%0t: %0d results outstanding, expected 0 actual %0d", $time,
               pending_outputs.size(), pending_outputs.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
